### hdl/lcl_pkg.sv
// shared types, codes and constants of the lattice cosine energy core
// no dependencies
package lcl_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int ADDR_W     = 12;
  localparam int NODE_W     = 13;
  localparam int ANGLE_BITS = 24;
  localparam int TURN_W     = 32;
  localparam int IY_W       = 7;
  localparam int BIT_W      = 3;

  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] K1  = 32'd1686629713;
  localparam logic [31:0] K3  = 32'd693598668;
  localparam logic [31:0] K5  = 32'd85569306;
  localparam logic [31:0] K7  = 32'd5026995;
  localparam logic [31:0] K9  = 32'd172272;
  localparam logic [31:0] K11 = 32'd3864;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_ENERGY = 2'd1;
  localparam logic [1:0] CMD_GRAD   = 2'd2;
  localparam logic [1:0] CMD_DELTA  = 2'd3;

  localparam logic [1:0] REG_DIMS  = 2'd0;
  localparam logic [1:0] REG_PPA   = 2'd1;
  localparam logic [1:0] REG_NODES = 2'd2;
  localparam logic [1:0] REG_COEF  = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [ADDR_W-1:0]     node_index;
    logic [ANGLE_BITS-1:0] angle;
  } in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               status;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WR, OP_SRCH, OP_IX, OP_RDME, OP_LATME, OP_PART,
    OP_LATP, OP_TSET, OP_TSQ, OP_TH, OP_TFIN, OP_WEIGH, OP_ACC, OP_NEXT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [BIT_W-1:0] sbit;
    logic [1:0]      slot;
    logic [2:0]      h;
    logic            pass;
  } ctl_t;

  typedef struct packed {
    logic is_write;
    logic is_energy;
    logic is_delta;
    logic bad;
    logic walk_empty;
    logic walk_last;
    logic slot_exists;
  } sts_t;

endpackage

### hdl/lcl_dp.sv
// datapath: angle store, configuration registers, row search, shared multiplier,
// sine polynomial and accumulator; depends on lcl_pkg
module lcl_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcl_pkg::ctl_t       ctl_i,
  output lcl_pkg::sts_t       sts_o,
  input  lcl_pkg::in_t        req_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  output lcl_pkg::out_t       result_o
);
  import lcl_pkg::*;

  logic [ANGLE_BITS-1:0] mem [MAX_NODES];
  logic [ANGLE_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]     raddr;

  logic [1:0]  dims_q;
  logic [12:0] ppa_q, nc_q;
  logic [23:0] coef_q;

  logic [1:0]            cmd_q;
  logic [ADDR_W-1:0]     idx_q;
  logic [ANGLE_BITS-1:0] ang_q;
  logic                  bad_q;
  logic [NODE_W-1:0]     node_q;
  logic [IY_W-1:0]       iy_q, ix_q;
  logic [TURN_W-1:0]     me_q, pt_q, t_q, t2_q, p_q;
  logic                  zpt_q, neg_q, xneg_q;
  logic signed [33:0]    x_q;
  logic [63:0]           prod_q;
  logic signed [63:0]    acc_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  function automatic logic [12:0] tri_num(input logic [IY_W-1:0] c);
    logic [13:0] pr;
    pr = 14'(c) * 14'(c - IY_W'(1));
    return pr[13:1];
  endfunction

  // search candidate
  logic [IY_W-1:0] cand;
  assign cand = iy_q | (IY_W'(1) << ctl_i.sbit);

  // partner slot decode
  logic              s_exist, s_bound;
  logic [NODE_W-1:0] s_addr;
  logic              has_right;
  assign has_right = ({1'b0, ix_q} + 8'd1) < {1'b0, iy_q};

  always_comb begin
    s_exist = 1'b0;
    s_bound = 1'b0;
    s_addr  = node_q;
    if (dims_q == 2'd1) begin
      unique case (ctl_i.slot)
        2'd0: begin
          s_exist = 1'b1;
          s_bound = (node_q == '0);
          s_addr  = node_q - NODE_W'(1);
        end
        2'd1: begin
          s_exist = ({1'b0, node_q} + 14'd1) < {1'b0, ppa_q};
          s_addr  = node_q + NODE_W'(1);
        end
        default: s_exist = 1'b0;
      endcase
    end else if (dims_q == 2'd2) begin
      unique case (ctl_i.slot)
        2'd0: begin
          s_exist = (ix_q != '0);
          s_addr  = node_q - NODE_W'(1);
        end
        2'd1: begin
          s_exist = (13'(iy_q) + 13'd1) < ppa_q;
          s_addr  = node_q + NODE_W'(iy_q);
        end
        2'd2: begin
          s_exist = 1'b1;
          s_bound = !has_right;
          s_addr  = node_q + NODE_W'(1);
        end
        default: begin
          s_exist = has_right;
          s_addr  = node_q + NODE_W'(1) - NODE_W'(iy_q);
        end
      endcase
    end
  end

  logic [12:0] walk;
  assign walk = (nc_q > 13'(MAX_NODES)) ? 13'(MAX_NODES) : nc_q;

  assign sts_o.is_write    = (cmd_q == CMD_WRITE);
  assign sts_o.is_energy   = (cmd_q == CMD_ENERGY);
  assign sts_o.is_delta    = (cmd_q == CMD_DELTA);
  assign sts_o.bad         = bad_q;
  assign sts_o.walk_empty  = (nc_q == '0);
  assign sts_o.walk_last   = ({1'b0, node_q} + 14'd1) >= {1'b0, walk};
  assign sts_o.slot_exists = s_exist;

  // trig argument
  logic [TURN_W-1:0] arg;
  always_comb begin
    arg = (ctl_i.pass ? {ang_q, 8'b0} : me_q) - pt_q;
    if (cmd_q != CMD_GRAD) arg = arg + QUARTER;
  end

  function automatic logic [31:0] kcoef(input logic [2:0] h);
    case (h)
      3'd0:    return K9;
      3'd1:    return K7;
      3'd2:    return K5;
      3'd3:    return K3;
      default: return K1;
    endcase
  endfunction

  logic signed [33:0] mag_s;
  assign mag_s = x_q[33] ? -x_q : x_q;

  always_comb begin
    mul_a = t_q;
    mul_b = t_q;
    case (ctl_i.op)
      OP_TH: begin
        mul_a = t2_q;
        mul_b = (ctl_i.h == 3'd0) ? K11 : p_q;
      end
      OP_TFIN: mul_b = p_q;
      OP_WEIGH: begin
        mul_a = 32'(coef_q);
        mul_b = mag_s[31:0];
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic [33:0]        m_raw, m_c;
  logic signed [33:0] val;
  assign m_raw = mul_p[63:30];
  assign m_c   = (m_raw > 34'(ONE_Q30)) ? 34'(ONE_Q30) : m_raw;
  assign val   = neg_q ? -$signed(m_c) : $signed(m_c);

  logic [41:0] pos_sh, neg_sh;
  assign pos_sh = prod_q[63:22];
  assign neg_sh = 42'((65'(prod_q) + 65'd4194303) >> 22);

  assign raddr = (ctl_i.op == OP_RDME) ? node_q[ADDR_W-1:0] : s_addr[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_WR) mem[idx_q] <= ang_q;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 2'd2;
      ppa_q  <= 13'd64;
      nc_q   <= 13'd2016;
      coef_q <= 24'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DIMS:  dims_q <= cfg_data_i[1:0];
        REG_PPA:   ppa_q  <= cfg_data_i[12:0];
        REG_NODES: nc_q   <= cfg_data_i[12:0];
        REG_COEF:  coef_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        cmd_q  <= req_i.cmd;
        idx_q  <= req_i.node_index;
        ang_q  <= req_i.angle;
        bad_q  <= (req_i.cmd != CMD_ENERGY) && (13'(req_i.node_index) >= nc_q);
        node_q <= (req_i.cmd == CMD_ENERGY) ? '0 : NODE_W'(req_i.node_index);
        iy_q   <= '0;
        acc_q  <= '0;
      end
      OP_SRCH:  if (tri_num(cand) <= node_q) iy_q <= cand;
      OP_IX:    ix_q <= IY_W'(node_q - tri_num(iy_q));
      OP_LATME: me_q <= {rdata_q, 8'b0};
      OP_PART:  zpt_q <= s_bound || s_addr[NODE_W-1];
      OP_LATP:  pt_q <= zpt_q ? '0 : {rdata_q, 8'b0};
      OP_TSET: begin
        t_q   <= arg[30] ? ONE_Q30 - {2'b0, arg[29:0]} : {2'b0, arg[29:0]};
        neg_q <= arg[31];
      end
      OP_TSQ:  t2_q <= mul_p[61:30];
      OP_TH:   p_q  <= kcoef(ctl_i.h) - mul_p[61:30];
      OP_TFIN: begin
        if (ctl_i.pass)                x_q <= x_q - val;
        else if (cmd_q == CMD_ENERGY)  x_q <= $signed(34'(ONE_Q30)) - val;
        else                           x_q <= val;
      end
      OP_WEIGH: begin
        prod_q <= mul_p;
        xneg_q <= x_q[33];
      end
      OP_ACC:  acc_q <= xneg_q ? acc_q - $signed(64'(neg_sh))
                               : acc_q + $signed(64'(pos_sh));
      OP_NEXT: begin
        node_q <= node_q + NODE_W'(1);
        iy_q   <= '0;
      end
      default: ;
    endcase
  end

  assign result_o.result_value = acc_q;
  assign result_o.status       = bad_q;

endmodule

### hdl/lcl_ctrl.sv
// controller: sequences load, row search, partner reads, polynomial steps
// and accumulation; depends on lcl_pkg
module lcl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           done_o,
  input  lcl_pkg::sts_t  sts_i,
  output lcl_pkg::ctl_t  ctl_o
);
  import lcl_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'b0_0000_0000_0000_0001,
    ST_DISP  = 17'b0_0000_0000_0000_0010,
    ST_WR    = 17'b0_0000_0000_0000_0100,
    ST_SRCH  = 17'b0_0000_0000_0000_1000,
    ST_IX    = 17'b0_0000_0000_0001_0000,
    ST_RDME  = 17'b0_0000_0000_0010_0000,
    ST_LATME = 17'b0_0000_0000_0100_0000,
    ST_SLOT  = 17'b0_0000_0000_1000_0000,
    ST_LATP  = 17'b0_0000_0001_0000_0000,
    ST_TSET  = 17'b0_0000_0010_0000_0000,
    ST_TSQ   = 17'b0_0000_0100_0000_0000,
    ST_TH    = 17'b0_0000_1000_0000_0000,
    ST_TFIN  = 17'b0_0001_0000_0000_0000,
    ST_WEIGH = 17'b0_0010_0000_0000_0000,
    ST_ACC   = 17'b0_0100_0000_0000_0000,
    ST_DONE  = 17'b0_1000_0000_0000_0000,
    ST_NEXT  = 17'b1_0000_0000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic [1:0]      slot_q, slot_d;
  logic [2:0]      h_q, h_d;
  logic            pass_q, pass_d;
  logic            node_end;

  always_comb begin
    state_d  = state_q;
    bit_d    = bit_q;
    slot_d   = slot_q;
    h_d      = h_q;
    pass_d   = pass_q;
    node_end = 1'b0;
    ctl_o.op = OP_NONE;
    unique case (state_q)
      ST_IDLE: if (start_i) begin
        ctl_o.op = OP_LOAD;
        state_d  = ST_DISP;
      end
      ST_DISP: begin
        bit_d = BIT_W'(IY_W - 1);
        if (sts_i.is_write)       state_d = ST_WR;
        else if (sts_i.is_energy) state_d = sts_i.walk_empty ? ST_DONE : ST_SRCH;
        else                      state_d = sts_i.bad ? ST_DONE : ST_SRCH;
      end
      ST_WR: begin
        ctl_o.op = OP_WR;
        state_d  = ST_DONE;
      end
      ST_SRCH: begin
        ctl_o.op = OP_SRCH;
        if (bit_q == '0) state_d = ST_IX;
        else             bit_d   = bit_q - BIT_W'(1);
      end
      ST_IX: begin
        ctl_o.op = OP_IX;
        state_d  = ST_RDME;
      end
      ST_RDME: begin
        ctl_o.op = OP_RDME;
        state_d  = ST_LATME;
      end
      ST_LATME: begin
        ctl_o.op = OP_LATME;
        slot_d   = 2'd0;
        state_d  = ST_SLOT;
      end
      ST_SLOT: begin
        if (sts_i.slot_exists) begin
          ctl_o.op = OP_PART;
          state_d  = ST_LATP;
        end else if (slot_q == 2'd3) begin
          node_end = 1'b1;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_LATP: begin
        ctl_o.op = OP_LATP;
        pass_d   = 1'b0;
        state_d  = ST_TSET;
      end
      ST_TSET: begin
        ctl_o.op = OP_TSET;
        state_d  = ST_TSQ;
      end
      ST_TSQ: begin
        ctl_o.op = OP_TSQ;
        h_d      = 3'd0;
        state_d  = ST_TH;
      end
      ST_TH: begin
        ctl_o.op = OP_TH;
        if (h_q == 3'd4) state_d = ST_TFIN;
        else             h_d     = h_q + 3'd1;
      end
      ST_TFIN: begin
        ctl_o.op = OP_TFIN;
        if (sts_i.is_delta && !pass_q) begin
          pass_d  = 1'b1;
          state_d = ST_TSET;
        end else begin
          state_d = ST_WEIGH;
        end
      end
      ST_WEIGH: begin
        ctl_o.op = OP_WEIGH;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        ctl_o.op = OP_ACC;
        if (slot_q == 2'd3) begin
          // the step to the next node waits in ST_NEXT so this term lands
          if (sts_i.is_energy && !sts_i.walk_last) state_d = ST_NEXT;
          else                                     node_end = 1'b1;
        end else begin
          slot_d  = slot_q + 2'd1;
          state_d = ST_SLOT;
        end
      end
      ST_NEXT: node_end = 1'b1;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (node_end) begin
      if (sts_i.is_energy && !sts_i.walk_last) begin
        ctl_o.op = OP_NEXT;
        bit_d    = BIT_W'(IY_W - 1);
        state_d  = ST_SRCH;
      end else begin
        state_d = ST_DONE;
      end
    end
  end

  assign ctl_o.sbit = bit_q;
  assign ctl_o.slot = slot_q;
  assign ctl_o.h    = h_q;
  assign ctl_o.pass = pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      slot_q  <= '0;
      h_q     <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      slot_q  <= slot_d;
      h_q     <= h_d;
      pass_q  <= pass_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q == ST_DISP)
    else $error("accepted word not dispatched");

  a_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH && bit_q != '0) |=>
      (state_q == ST_SRCH && bit_q == $past(bit_q) - BIT_W'(1)))
    else $error("row search skipped a bit");

  a_tfin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TFIN && !(sts_i.is_delta && !pass_q)) |=> state_q == ST_WEIGH)
    else $error("edge term not weighed");

endmodule

### hdl/lattice_cosine_laplacian_symbol_core.sv
// top level of the lattice cosine energy core
// instantiates lcl_ctrl and lcl_dp; depends on lcl_pkg
//
// Usage: a command word on req_i is taken at a clock edge with start_i high and
// busy_o low. Commands write an angle, sum the total energy, or give the
// gradient or the energy change of a proposal at one node. Exactly one result
// word follows per command: result_o is valid in the single cycle in which
// done_o is high; the receiver cannot stall it. busy_o stays high until after
// that cycle, so one command is in flight at a time.
// After the accepting edge a write passes dispatch and the store write, then
// strobes; an out-of-range query goes from dispatch to the strobe. A node query
// passes dispatch, the 7-step row search and the node read, then visits each
// partner slot in turn; for a slot with a partner it steps the sine polynomial
// on the single shared 32x32 multiplier, twice for a proposal delta, then weighs
// and adds the term, and at the end it strobes. Total energy repeats the search,
// read and slots over min(node_count, 4096) nodes. A new word is taken the cycle
// after the strobe. The user keeps to this: the config channel (cfg_valid_i,
// always ready) is written while idle; the core itself does not enforce it.
// Reset restores the config defaults; the angle store holds garbage until written.
module lattice_cosine_laplacian_symbol_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  lcl_pkg::in_t   req_i,
  output logic           done_o,
  output lcl_pkg::out_t  result_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [23:0]    cfg_data_i
);
  import lcl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  lcl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  lcl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule
